// File: hw/rtl/ovb_pkg.sv
// Package for the octahedral view basis block.
// Holds the fixed-point widths, the status codes and the result types.
// No dependencies.
package ovb_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int MAX_GRID  = 64;
    localparam int NUDGE     = 10000;

    localparam int GRID_W = 7;
    localparam int IDX_W  = 13;
    localparam int COMP_W = 16;
    localparam int MAG_W  = 26;
    localparam int Q_W    = 54;
    localparam int X_W    = 62;
    localparam int R_W    = 63;
    localparam int DEN_W  = 32;
    localparam int QUO_W  = 16;

    localparam int SQ_STEPS = 32;
    localparam int UNIT_LAT = 1 + 1 + 1 + SQ_STEPS + 1 + QUO_W + 1;

    localparam logic [GRID_W-1:0] RESET_GRID = 7'd8;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef logic [MAG_W-1:0]         t_mag;
    typedef logic signed [COMP_W-1:0] t_comp;

    typedef struct packed {
        t_comp x;
        t_comp y;
        t_comp z;
    } t_vec3;

    typedef struct packed {
        t_vec3   right;
        t_vec3   up;
        t_vec3   dir;
        t_status status;
    } t_result;

endpackage

// File: hw/rtl/ovb_div_cell.sv
// One restoring division step: shifts one numerator bit into the remainder.
// The quotient bit replaces the consumed numerator bit. Used in every divider chain.
// Depends on nothing.
module ovb_div_cell #(
    parameter int DW = 8,
    parameter int NW = 8,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic [DW-1:0] o_rem,
    output logic [NW-1:0] o_num,
    output logic [DW-1:0] o_den,
    output logic [SW-1:0] o_side
);

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] n_num;

    always_comb begin
        w_trial = {i_rem, i_num[NW-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_ge    = w_trial >= {1'b0, i_den};
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        n_num   = {i_num[NW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_num  <= n_num;
            o_den  <= i_den;
            o_side <= i_side;
        end
    end

endmodule

// File: hw/rtl/ovb_sqrt_cell.sv
// One step of the bit-pair integer square root, for one fixed bit position.
// Carries the operand, the partial root and a sideband to the next cell.
// Depends on ovb_pkg.
module ovb_sqrt_cell #(
    parameter int STEP = 0,
    parameter int SW   = 1
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [ovb_pkg::X_W-1:0] i_x,
    input  logic [ovb_pkg::R_W-1:0] i_r,
    input  logic [SW-1:0]           i_side,
    output logic [ovb_pkg::X_W-1:0] o_x,
    output logic [ovb_pkg::R_W-1:0] o_r,
    output logic [SW-1:0]           o_side
);

    import ovb_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (2 * (SQ_STEPS - 1 - STEP));

    logic [63:0]    w_sum;
    logic           w_ge;
    logic [X_W-1:0] n_x;
    logic [R_W-1:0] n_r;

    always_comb begin
        w_sum = {1'b0, i_r} + BIT;
        w_ge  = {2'b0, i_x} >= w_sum;
        n_x   = w_ge ? i_x - w_sum[X_W-1:0] : i_x;
        n_r   = w_ge ? (i_r >> 1) + BIT[R_W-1:0] : (i_r >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= n_x;
            o_r    <= n_r;
            o_side <= i_side;
        end
    end

endmodule

// File: hw/rtl/ovb_unit.sv
// Fixed-point vector normalizer: squares, scale search, square-root chain,
// three divider chains and a clamp; every stage advances only while enabled.
// Depends on ovb_pkg, ovb_sqrt_cell and ovb_div_cell.
module ovb_unit (
    input  logic           i_clk,
    input  logic           i_en,
    input  ovb_pkg::t_mag  i_mag [3],
    input  logic [2:0]     i_neg,
    output ovb_pkg::t_vec3 o_vec
);

    import ovb_pkg::*;

    localparam int SQ_SW = 3 * MAG_W + 5 + 3;
    localparam int DV_SW = 2;

    t_mag           r_m0 [3];
    logic [2:0]     r_neg0;
    logic [Q_W-1:0] r_q0;
    t_mag           r_mx0;

    t_mag           r_m1 [3];
    logic [2:0]     r_neg1;
    logic [Q_W-1:0] r_q1;
    logic [4:0]     r_g1;
    logic [4:0]     n_g;

    t_mag           r_m2 [3];
    logic [2:0]     r_neg2;
    logic [X_W-1:0] r_x2;
    logic [4:0]     r_g2;

    logic [X_W-1:0]   w_sx [SQ_STEPS+1];
    logic [R_W-1:0]   w_sr [SQ_STEPS+1];
    logic [SQ_SW-1:0] w_ss [SQ_STEPS+1];

    t_mag           w_sm [3];
    logic [4:0]     w_sg;
    logic [2:0]     w_sneg;
    logic [DEN_W-1:0] w_root;
    logic [63:0]    w_numer [3];

    logic [DEN_W-1:0] w_drem [3][QUO_W+1];
    logic [QUO_W-1:0] w_dnum [3][QUO_W+1];
    logic [DEN_W-1:0] w_dden [3][QUO_W+1];
    logic [DV_SW-1:0] w_dside[3][QUO_W+1];

    logic [COMP_W-1:0] w_clamp [3];
    t_comp             r_out [3];

    always_comb begin
        n_g = '0;
        for (int h = 1; h <= 31; h++) begin
            if ((r_q0 >> (X_W - 2 * h)) == '0 && (r_mx0 >> (X_W - FRAC_BITS - h)) == '0) begin
                n_g = 5'(h);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_m0[k] <= i_mag[k];
            end
            r_neg0 <= i_neg;
            r_q0   <= Q_W'(i_mag[0]) * Q_W'(i_mag[0]) + Q_W'(i_mag[1]) * Q_W'(i_mag[1])
                      + Q_W'(i_mag[2]) * Q_W'(i_mag[2]);
            if (i_mag[0] >= i_mag[1] && i_mag[0] >= i_mag[2]) begin
                r_mx0 <= i_mag[0];
            end else if (i_mag[1] >= i_mag[2]) begin
                r_mx0 <= i_mag[1];
            end else begin
                r_mx0 <= i_mag[2];
            end

            r_m1   <= r_m0;
            r_neg1 <= r_neg0;
            r_q1   <= r_q0;
            r_g1   <= n_g;

            r_m2   <= r_m1;
            r_neg2 <= r_neg1;
            r_x2   <= X_W'(r_q1) << {r_g1, 1'b0};
            r_g2   <= r_g1;
        end
    end

    assign w_sx[0] = r_x2;
    assign w_sr[0] = '0;
    assign w_ss[0] = {r_m2[0], r_m2[1], r_m2[2], r_g2, r_neg2};

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        ovb_sqrt_cell #(
            .STEP (j),
            .SW   (SQ_SW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_x    (w_sx[j]),
            .i_r    (w_sr[j]),
            .i_side (w_ss[j]),
            .o_x    (w_sx[j+1]),
            .o_r    (w_sr[j+1]),
            .o_side (w_ss[j+1])
        );
    end

    always_comb begin
        {w_sm[0], w_sm[1], w_sm[2], w_sg, w_sneg} = w_ss[SQ_STEPS];
        w_root = w_sr[SQ_STEPS][DEN_W-1:0];
        for (int k = 0; k < 3; k++) begin
            w_numer[k] = (64'(w_sm[k]) << (7'(FRAC_BITS) + 7'(w_sg)))
                         + 64'(w_root >> 1);
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_comp
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                w_drem[k][0]  <= {1'b0, w_numer[k][QUO_W+DEN_W-2:QUO_W]};
                w_dnum[k][0]  <= w_numer[k][QUO_W-1:0];
                w_dden[k][0]  <= w_root;
                w_dside[k][0] <= {w_sneg[2-k], w_root == '0};
            end
        end

        for (genvar j = 0; j < QUO_W; j++) begin : g_div
            ovb_div_cell #(
                .DW (DEN_W),
                .NW (QUO_W),
                .SW (DV_SW)
            ) u_cell (
                .i_clk  (i_clk),
                .i_en   (i_en),
                .i_rem  (w_drem[k][j]),
                .i_num  (w_dnum[k][j]),
                .i_den  (w_dden[k][j]),
                .i_side (w_dside[k][j]),
                .o_rem  (w_drem[k][j+1]),
                .o_num  (w_dnum[k][j+1]),
                .o_den  (w_dden[k][j+1]),
                .o_side (w_dside[k][j+1])
            );
        end

        always_comb begin
            if (w_dside[k][QUO_W][0]) begin
                w_clamp[k] = '0;
            end else if (w_dnum[k][QUO_W] > COMP_W'(ONE)) begin
                w_clamp[k] = COMP_W'(ONE);
            end else begin
                w_clamp[k] = w_dnum[k][QUO_W];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_out[k] <= w_dside[k][QUO_W][1] ? -$signed(w_clamp[k]) : $signed(w_clamp[k]);
            end
        end
    end

    assign o_vec = '{x: r_out[0], y: r_out[1], z: r_out[2]};

endmodule

// File: hw/rtl/octahedral_view_basis.sv
// Octahedral view basis: view index to camera right, up and direction axes.
// An accepted request passes the index divider chain, the staging registers and the unit pipelines.
// Throughput: one request per cycle; the pipeline holds when two results wait.
// The square-root and divider cell chains are pipelined, one step per cell.
// Reset clears the pipeline valid bits and the output queue and sets grid size 8.
// Depends on ovb_pkg, ovb_div_cell and ovb_unit.
module octahedral_view_basis (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ovb_pkg::GRID_W-1:0] i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [ovb_pkg::IDX_W-1:0]  i_view_index,
    output logic                       o_valid,
    input  logic                       i_ready,
    output ovb_pkg::t_comp             o_right_x,
    output ovb_pkg::t_comp             o_right_y,
    output ovb_pkg::t_comp             o_right_z,
    output ovb_pkg::t_comp             o_up_x,
    output ovb_pkg::t_comp             o_up_y,
    output ovb_pkg::t_comp             o_up_z,
    output ovb_pkg::t_comp             o_dir_x,
    output ovb_pkg::t_comp             o_dir_y,
    output ovb_pkg::t_comp             o_dir_z,
    output logic [1:0]                 o_status
);

    import ovb_pkg::*;

    localparam int A_W = 6;
    localparam int TOT = 10 + UNIT_LAT;

    logic [GRID_W-1:0] r_grid;
    logic              w_en;
    logic              w_acc;
    logic [TOT-1:0]    r_vld;

    logic [2*GRID_W-1:0] w_nn;
    logic                w_oor;
    logic                w_upper;
    logic [2*GRID_W-1:0] w_ip;

    logic [GRID_W-1:0] w_rem  [A_W+1];
    logic [A_W-1:0]    w_num  [A_W+1];
    logic [GRID_W-1:0] w_den  [A_W+1];
    logic [1:0]        w_side [A_W+1];

    logic signed [8:0] w_d, w_x, w_y, w_ax, w_ay, w_z, w_cm, w_c;
    t_status           w_st1;

    logic signed [7:0] r1_x, r1_y, r1_c;
    logic              r1_nudge;
    t_status           r1_st;

    logic [6:0]  w_ax2, w_ay2, w_ac2;
    logic [20:0] r2_kx, r2_ky;
    logic [6:0]  r2_ax, r2_ay, r2_ac;
    logic [13:0] r2_cx, r2_cy;
    logic [14:0] r2_sq;
    logic        r2_nudge, r2_xn, r2_yn, r2_cn;
    t_status     r2_st;

    t_mag        r3_dmag [3];
    t_mag        r3_rmag [3];
    t_mag        r3_umag [3];
    logic [2:0]  r3_dneg, r3_rneg, r3_uneg;
    t_status     r3_st;
    t_status     r_st_d [UNIT_LAT];

    t_vec3       w_right, w_up, w_dir;
    t_result     w_res;
    t_result     r_fifo [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_push, w_pop;

    assign w_en    = r_cnt != 2'd2;
    assign o_ready = w_en;
    assign w_acc   = i_valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= RESET_GRID;
        end else if (i_cfg_we) begin
            r_grid <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOT-2:0], i_valid};
        end
    end

    always_comb begin
        w_nn    = (2*GRID_W)'(r_grid) * (2*GRID_W)'(r_grid);
        w_oor   = r_grid < GRID_W'(2) || r_grid > GRID_W'(MAX_GRID)
                  || (2*GRID_W+1)'(i_view_index) >= {w_nn, 1'b0};
        w_upper = (2*GRID_W)'(i_view_index) >= w_nn;
        w_ip    = w_upper ? (2*GRID_W)'(i_view_index) - w_nn : (2*GRID_W)'(i_view_index);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            w_rem[0]  <= {1'b0, w_ip[2*A_W-1:A_W]};
            w_num[0]  <= w_ip[A_W-1:0];
            w_den[0]  <= r_grid;
            w_side[0] <= {w_upper, w_oor};
        end
    end

    for (genvar j = 0; j < A_W; j++) begin : g_idx
        ovb_div_cell #(
            .DW (GRID_W),
            .NW (A_W),
            .SW (2)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_rem[j]),
            .i_num  (w_num[j]),
            .i_den  (w_den[j]),
            .i_side (w_side[j]),
            .o_rem  (w_rem[j+1]),
            .o_num  (w_num[j+1]),
            .o_den  (w_den[j+1]),
            .o_side (w_side[j+1])
        );
    end

    always_comb begin
        w_d  = $signed({2'b0, w_den[A_W]}) - 9'sd1;
        w_x  = $signed({3'b0, w_num[A_W]}) + $signed({3'b0, w_rem[A_W][A_W-1:0]}) - w_d;
        w_y  = $signed({3'b0, w_num[A_W]}) - $signed({3'b0, w_rem[A_W][A_W-1:0]});
        w_ax = w_x[8] ? -w_x : w_x;
        w_ay = w_y[8] ? -w_y : w_y;
        w_z  = w_d - w_ax - w_ay;
        w_cm = (w_z == '0) ? w_d : w_z;
        w_c  = w_side[A_W][1] ? w_cm : -w_cm;
        if (w_side[A_W][0]) begin
            w_st1 = ST_RANGE;
        end else if (w_x == '0 && w_y == '0) begin
            w_st1 = ST_DEGEN;
        end else begin
            w_st1 = ST_OK;
        end
    end

    always_comb begin
        w_ax2 = r1_x[7] ? 7'(-r1_x) : r1_x[6:0];
        w_ay2 = r1_y[7] ? 7'(-r1_y) : r1_y[6:0];
        w_ac2 = r1_c[7] ? 7'(-r1_c) : r1_c[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x     <= w_x[7:0];
            r1_y     <= w_y[7:0];
            r1_c     <= w_c[7:0];
            r1_nudge <= w_z == '0;
            r1_st    <= w_st1;

            r2_ax    <= w_ax2;
            r2_ay    <= w_ay2;
            r2_ac    <= w_ac2;
            r2_kx    <= r1_nudge ? 21'(w_ax2) * 21'(NUDGE) : 21'(w_ax2);
            r2_ky    <= r1_nudge ? 21'(w_ay2) * 21'(NUDGE) : 21'(w_ay2);
            r2_cx    <= 14'(w_ac2) * 14'(w_ax2);
            r2_cy    <= 14'(w_ac2) * 14'(w_ay2);
            r2_sq    <= 15'(w_ax2) * 15'(w_ax2) + 15'(w_ay2) * 15'(w_ay2);
            r2_nudge <= r1_nudge;
            r2_xn    <= r1_x[7];
            r2_yn    <= r1_y[7];
            r2_cn    <= r1_c[7];
            r2_st    <= r1_st;

            r3_dmag[0] <= MAG_W'(r2_kx);
            r3_dmag[1] <= MAG_W'(r2_ky);
            r3_dmag[2] <= MAG_W'(r2_ac);
            r3_dneg    <= {r2_xn, r2_yn, r2_cn};
            r3_rmag[0] <= MAG_W'(r2_ay);
            r3_rmag[1] <= MAG_W'(r2_ax);
            r3_rmag[2] <= '0;
            r3_rneg    <= {!r2_yn, r2_xn, 1'b0};
            r3_umag[0] <= MAG_W'(r2_cx);
            r3_umag[1] <= MAG_W'(r2_cy);
            r3_umag[2] <= r2_nudge ? MAG_W'(30'(r2_sq) * 30'(NUDGE)) : MAG_W'(r2_sq);
            r3_uneg    <= {r2_cn == r2_xn, r2_cn == r2_yn, 1'b0};
            r3_st      <= r2_st;

            r_st_d[0] <= r3_st;
            for (int k = 1; k < UNIT_LAT; k++) begin
                r_st_d[k] <= r_st_d[k-1];
            end
        end
    end

    ovb_unit u_dir (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (r3_dmag),
        .i_neg (r3_dneg),
        .o_vec (w_dir)
    );

    ovb_unit u_right (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (r3_rmag),
        .i_neg (r3_rneg),
        .o_vec (w_right)
    );

    ovb_unit u_up (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (r3_umag),
        .i_neg (r3_uneg),
        .o_vec (w_up)
    );

    always_comb begin
        w_res.status = r_st_d[UNIT_LAT-1];
        w_res.right  = (w_res.status == ST_OK) ? w_right : '0;
        w_res.up     = (w_res.status == ST_OK) ? w_up : '0;
        w_res.dir    = (w_res.status == ST_RANGE) ? '0 : w_dir;
    end

    assign w_push = w_en && r_vld[TOT-1];
    assign w_pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    assign o_valid   = r_cnt != '0;
    assign o_right_x = r_fifo[r_rp].right.x;
    assign o_right_y = r_fifo[r_rp].right.y;
    assign o_right_z = r_fifo[r_rp].right.z;
    assign o_up_x    = r_fifo[r_rp].up.x;
    assign o_up_y    = r_fifo[r_rp].up.y;
    assign o_up_z    = r_fifo[r_rp].up.z;
    assign o_dir_x   = r_fifo[r_rp].dir.x;
    assign o_dir_y   = r_fifo[r_rp].dir.y;
    assign o_dir_z   = r_fifo[r_rp].dir.z;
    assign o_status  = r_fifo[r_rp].status;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("Output queue count out of bounds.");

    a_acc_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_vld[0])
        else $error("Accepted request did not enter the pipeline.");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_RANGE |-> o_dir_x == '0 && o_dir_y == '0
            && o_dir_z == '0 && o_up_z == '0 && o_right_x == '0)
        else $error("Out-of-range result carries nonzero vectors.");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_dir_x <= 16'sd16384 && o_dir_x >= -16'sd16384
            && o_up_z <= 16'sd16384 && o_up_z >= -16'sd16384)
        else $error("Axis component exceeds one.");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for octahedral_view_basis: drives view index requests,
// predicts the right, up and direction axes in fixed point and compares every result.
// Depends on ovb_pkg and the octahedral_view_basis RTL.
`timescale 1ns / 1ps

module testbench;
    import ovb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [GRID_W-1:0] i_cfg_wdata = '0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [IDX_W-1:0] i_view_index = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    t_comp            o_right_x, o_right_y, o_right_z;
    t_comp            o_up_x, o_up_y, o_up_z;
    t_comp            o_dir_x, o_dir_y, o_dir_z;
    logic [1:0]       o_status;

    octahedral_view_basis u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_view_index (i_view_index),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_right_x    (o_right_x),
        .o_right_y    (o_right_y),
        .o_right_z    (o_right_z),
        .o_up_x       (o_up_x),
        .o_up_y       (o_up_y),
        .o_up_z       (o_up_z),
        .o_dir_x      (o_dir_x),
        .o_dir_y      (o_dir_y),
        .o_dir_z      (o_dir_z),
        .o_status     (o_status)
    );

    logic [IDX_W-1:0]  pending_index[$];
    t_result           expected_basis[$];
    logic [GRID_W-1:0] grid_copy = RESET_GRID;
    bit                quiet = 1'b0;
    int                send_gap = 0;
    int                stall_left = 0;
    int                mismatches = 0;
    int                requests_sent = 0;
    int                results_seen = 0;
    int                cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_vec3 unit_axis(longint vx, longint vy, longint vz);
        longint          v[3];
        longint unsigned m[3];
        longint unsigned q, mx, r, c;
        int              g;
        t_comp           w[3];
        t_vec3           o;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        q = 0;
        mx = 0;
        g = 0;
        for (int k = 0; k < 3; k++) begin
            m[k] = v[k] < 0 ? -v[k] : v[k];
            q += m[k] * m[k];
            if (m[k] > mx) mx = m[k];
        end
        while (g < 31) begin
            if ((q >> (62 - 2 * (g + 1))) != 0) break;
            if ((mx >> (62 - FRAC_BITS - (g + 1))) != 0) break;
            g++;
        end
        r = int_sqrt(q << (2 * g));
        for (int k = 0; k < 3; k++) begin
            if (r == 0) begin
                w[k] = '0;
            end else begin
                c = ((m[k] << (FRAC_BITS + g)) + r / 2) / r;
                if (c > ONE) c = ONE;
                w[k] = v[k] < 0 ? -c : c;
            end
        end
        o.x = w[0];
        o.y = w[1];
        o.z = w[2];
        return o;
    endfunction

    function automatic t_result compute_basis(logic [IDX_W-1:0] idx, logic [GRID_W-1:0] n);
        t_result res;
        longint  i, s, d, a, b, x, y, z, kk, c;
        res = '0;
        res.status = ST_OK;
        i = idx;
        if (n < 2 || n > MAX_GRID || i >= 2 * n * n) begin
            res.status = ST_RANGE;
            return res;
        end
        s = -1;
        if (i >= n * n) begin
            s = 1;
            i -= n * n;
        end
        d = n - 1;
        a = i / n;
        b = i % n;
        x = a + b - d;
        y = a - b;
        z = s * (d - (x < 0 ? -x : x) - (y < 0 ? -y : y));
        kk = 1;
        c = z;
        if (z == 0) begin
            kk = NUDGE;
            c = s * d;
        end
        res.dir = unit_axis(kk * x, kk * y, c);
        if (x == 0 && y == 0) begin
            res.status = ST_DEGEN;
        end else begin
            res.right = unit_axis(-y, x, 0);
            res.up = unit_axis(-c * x, -c * y, kk * (x * x + y * y));
        end
        return res;
    endfunction

    task automatic report(string what, int got, int want);
        mismatches++;
        $display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want,
                 results_seen);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_basis = {expected_basis, compute_basis(i_view_index, grid_copy)};
                requests_sent++;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_index.size() > 0) begin
                    i_valid <= 1'b1;
                    i_view_index <= pending_index.pop_front();
                    if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 19);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_basis.size() == 0) begin
                    report("unexpected result", o_status, -1);
                end else begin
                    want = expected_basis.pop_front();
                    if (o_right_x !== want.right.x) report("right_x", o_right_x, want.right.x);
                    if (o_right_y !== want.right.y) report("right_y", o_right_y, want.right.y);
                    if (o_right_z !== want.right.z) report("right_z", o_right_z, want.right.z);
                    if (o_up_x !== want.up.x) report("up_x", o_up_x, want.up.x);
                    if (o_up_y !== want.up.y) report("up_y", o_up_y, want.up.y);
                    if (o_up_z !== want.up.z) report("up_z", o_up_z, want.up.z);
                    if (o_dir_x !== want.dir.x) report("dir_x", o_dir_x, want.dir.x);
                    if (o_dir_y !== want.dir.y) report("dir_y", o_dir_y, want.dir.y);
                    if (o_dir_z !== want.dir.z) report("dir_z", o_dir_z, want.dir.z);
                    if (o_status !== want.status) report("status", o_status, want.status);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 19);
            end
        end
    end

    task automatic wait_drained();
        while (pending_index.size() > 0 || i_valid || expected_basis.size() > 0)
            @(negedge i_clk);
        repeat (UNIT_LAT + 10) @(posedge i_clk);
    endtask

    task automatic set_grid(logic [GRID_W-1:0] n);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        grid_copy = n;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic queue_random(int count);
        int top;
        top = 2 * grid_copy * grid_copy - 1;
        if (top < 0 || top > 8191) top = 8191;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 85)
                pending_index = {pending_index, IDX_W'($urandom_range(0, top))};
            else
                pending_index = {pending_index, IDX_W'($urandom_range(0, 8191))};
        end
    endtask

    initial begin
        logic [GRID_W-1:0] sizes[12];
        sizes = '{7'd2, 7'd64, 7'd0, 7'd127, 7'd5, 7'd1, 7'd65,
                  7'd8, 7'd17, 7'd33, 7'd63, 7'd4};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset grid of 8: corners of both halves and the far end of the index range.
        pending_index = '{13'd0, 13'd7, 13'd63, 13'd64, 13'd127, 13'd128, 13'd8191};
        // Odd grid of 3 has an on-axis view in each half; 18 and up are out of range.
        set_grid(7'd3);
        for (int k = 0; k < 19; k++) pending_index = {pending_index, IDX_W'(k)};

        foreach (sizes[j]) begin
            set_grid(sizes[j]);
            queue_random(45);
        end
        for (int j = 0; j < 4; j++) begin
            set_grid(GRID_W'($urandom_range(2, 64)));
            queue_random(40);
        end
        wait_drained();
        quiet = 1'b1;
        queue_random(30);
        wait_drained();

        $display("Sent %0d view requests over 18 grid settings, including sizes out of range.",
                 requests_sent);
        $display("Checked %0d results with %0d field mismatches.", results_seen, mismatches);
        if (mismatches == 0 && expected_basis.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
